/* rtl/nhp_pkg.sv */
// nhp_pkg: shared types and constants for the netstring header parser
// no dependencies; imported by the parser core, result buffer and top level
package nhp_pkg;

	// default upper bound on the declared header length
	localparam int unsigned DEF_MAX_HEADER_LEN = 65535;

	// character codes the parser looks for
	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_NUL   = 8'h00;

	// status codes reported with every result word
	typedef enum logic [1:0] {
		ST_MORE   = 2'd0,
		ST_DONE   = 2'd1,
		ST_BADLEN = 2'd2,
		ST_NSERR  = 2'd3
	} status_t;

	// one result word
	typedef struct packed {
		logic [7:0] byte_out;
		logic       name_start;
		logic       name_end;
		logic       value_start;
		logic       value_end;
		logic       headers_done;
		status_t    status;
	} result_t;

endpackage

/* rtl/nhp_in_if.sv */
// nhp_in_if: valid/ready channel carrying request stream bytes
// no dependencies
interface nhp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       restart;

	modport source (output valid, output data_byte, output restart, input ready);
	modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

/* rtl/nhp_out_if.sv */
// nhp_out_if: valid/ready channel carrying parser result words
// no dependencies
interface nhp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_out;
	logic       name_start;
	logic       name_end;
	logic       value_start;
	logic       value_end;
	logic       headers_done;
	logic [1:0] status;

	modport source (output valid, output byte_out, output name_start, output name_end,
		output value_start, output value_end, output headers_done, output status,
		input ready);
	modport sink (input valid, input byte_out, input name_start, input name_end,
		input value_start, input value_end, input headers_done, input status,
		output ready);
endinterface

/* rtl/nhp_parse_core.sv */
// nhp_parse_core: input register, netstring state and per-byte decode
// depends on nhp_pkg and nhp_in_if
module nhp_parse_core #(
	parameter int unsigned MAX_HEADER_LEN = nhp_pkg::DEF_MAX_HEADER_LEN
) (
	input  logic              clk,
	input  logic              arst_n,
	nhp_in_if.sink            stream,
	output logic              res_valid,
	input  logic              res_ready,
	output nhp_pkg::result_t  res
);
	import nhp_pkg::*;

	localparam int unsigned LEN_W = $clog2(MAX_HEADER_LEN + 1);
	localparam int unsigned ACC_W = LEN_W + 4;
	localparam logic [ACC_W-1:0] MAX_LEN_ACC = ACC_W'(MAX_HEADER_LEN);

	typedef enum logic [2:0] {
		PH_LEN,
		PH_LEN_END,
		PH_NAME,
		PH_NAME_END,
		PH_VAL,
		PH_VAL_END,
		PH_DONE
	} phase_t;

	// input register
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        restart_s1;
	logic        advance;

	// parser state
	phase_t            phase_q, phase_n, phase_e;
	logic [LEN_W-1:0]  decl_len_q, decl_len_n, decl_len_e;
	logic [LEN_W-1:0]  remain_q, remain_n, remain_e;
	status_t           err_q, err_n, err_e;

	logic              is_digit;
	logic [ACC_W-1:0]  len_acc;
	logic              fail;
	logic              ns, ne, vs, ve, hd;
	status_t           st;

	assign advance      = valid_s1 && res_ready;
	assign stream.ready = !valid_s1 || res_ready;
	assign res_valid    = valid_s1;

	// capture the incoming word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid) begin
			byte_s1    <= stream.data_byte;
			restart_s1 <= stream.restart;
		end
	end

	// state as seen by this byte, after an optional restart
	always_comb begin
		phase_e    = restart_s1 ? PH_LEN : phase_q;
		decl_len_e = restart_s1 ? '0 : decl_len_q;
		remain_e   = restart_s1 ? '0 : remain_q;
		err_e      = restart_s1 ? ST_MORE : err_q;
	end

	// decimal accumulate: len * 10 + digit
	assign is_digit = (byte_s1 >= CHAR_ZERO) && (byte_s1 <= CHAR_NINE);
	assign len_acc  = (ACC_W'(decl_len_e) << 3) + (ACC_W'(decl_len_e) << 1)
		+ ACC_W'(byte_s1 - CHAR_ZERO);

	// per-byte decode
	always_comb begin
		phase_n    = phase_e;
		decl_len_n = decl_len_e;
		remain_n   = remain_e;
		err_n      = err_e;
		ns = 1'b0; ne = 1'b0; vs = 1'b0; ve = 1'b0; hd = 1'b0;
		st   = ST_MORE;
		fail = 1'b0;

		if (err_e != ST_MORE) begin
			st = err_e;
		end else begin
			unique case (phase_e)
				PH_LEN: begin
					if (byte_s1 == CHAR_COLON) begin
						remain_n = decl_len_e;
						phase_n  = PH_LEN_END;
					end else if (is_digit && (len_acc <= MAX_LEN_ACC)) begin
						decl_len_n = LEN_W'(len_acc);
					end else begin
						err_n = ST_BADLEN;
						st    = ST_BADLEN;
					end
				end
				PH_LEN_END, PH_NAME, PH_NAME_END, PH_VAL, PH_VAL_END: begin
					if (phase_e == PH_VAL_END && remain_e == '0) begin
						// count used up after a value: only a comma may follow
						if (byte_s1 == CHAR_COMMA) begin
							hd      = 1'b1;
							st      = ST_DONE;
							phase_n = PH_DONE;
						end else begin
							fail = 1'b1;
						end
					end else if (remain_e == '0) begin
						fail = 1'b1;
					end else begin
						remain_n = remain_e - LEN_W'(1);
						ns = (phase_e == PH_LEN_END) || (phase_e == PH_VAL_END);
						vs = (phase_e == PH_NAME_END);
						if (ns || phase_e == PH_NAME) begin
							// name byte
							if (byte_s1 == CHAR_NUL) begin
								ne      = 1'b1;
								phase_n = PH_NAME_END;
							end else begin
								phase_n = PH_NAME;
							end
						end else begin
							// value byte
							if (byte_s1 == CHAR_NUL) begin
								ve      = 1'b1;
								phase_n = PH_VAL_END;
							end else begin
								phase_n = PH_VAL;
							end
						end
					end
					if (fail) begin
						err_n    = ST_NSERR;
						st       = ST_NSERR;
						remain_n = remain_e;
						phase_n  = phase_e;
						ns = 1'b0; ne = 1'b0; vs = 1'b0; ve = 1'b0; hd = 1'b0;
					end
				end
				PH_DONE: begin
					st = ST_DONE;
				end
				default: begin
					st = ST_DONE;
				end
			endcase
		end
	end

	// result word
	always_comb begin
		res.byte_out     = byte_s1;
		res.name_start   = ns;
		res.name_end     = ne;
		res.value_start  = vs;
		res.value_end    = ve;
		res.headers_done = hd;
		res.status       = st;
	end

	// state update as the word moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_LEN;
			decl_len_q <= '0;
			remain_q   <= '0;
			err_q      <= ST_MORE;
		end else if (advance) begin
			phase_q    <= phase_n;
			decl_len_q <= decl_len_n;
			remain_q   <= remain_n;
			err_q      <= err_n;
		end
	end

endmodule

/* rtl/nhp_out_buf.sv */
// nhp_out_buf: two-entry result register that decouples the parser from the sink
// depends on nhp_pkg and nhp_out_if
module nhp_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_valid,
	output logic              res_ready,
	input  nhp_pkg::result_t  res,
	nhp_out_if.source         marks
);
	import nhp_pkg::*;

	result_t     data_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        push;
	logic        pop;
	result_t     head;

	assign res_ready = (count_q != 2'd2);
	assign push      = res_valid && res_ready;
	assign pop       = marks.valid && marks.ready;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wr_ptr_q] <= res;
		end
	end

	// drive the outgoing word
	assign head               = data_q[rd_ptr_q];
	assign marks.valid        = (count_q != 2'd0);
	assign marks.byte_out     = head.byte_out;
	assign marks.name_start   = head.name_start;
	assign marks.name_end     = head.name_end;
	assign marks.value_start  = head.value_start;
	assign marks.value_end    = head.value_end;
	assign marks.headers_done = head.headers_done;
	assign marks.status       = head.status;

endmodule

/* rtl/netstring_header_parser_unit.sv */
// netstring_header_parser_unit: top level of the netstring header parser
// depends on nhp_pkg, nhp_in_if, nhp_out_if, nhp_parse_core, nhp_out_buf
//
//  channel  dir  payload                                             handshake
//  stream   in   data_byte[7:0], restart                             valid/ready
//  marks    out  byte_out[7:0], name/value start/end, headers_done,  valid/ready
//                status[1:0]
//
// one byte accepted per cycle while not stalled; a result word is offered once its
// byte has passed the input register, then a two-entry result register
// the per-byte decode and length accumulate sit between those two registers
// arst_n clears the parser to await length digits and empties both registers
// a stalled sink fills the result register; input stalls only once both entries
// and the input register hold words
module netstring_header_parser_unit #(
	parameter int unsigned MAX_HEADER_LEN = nhp_pkg::DEF_MAX_HEADER_LEN
) (
	input  logic      clk,
	input  logic      arst_n,
	nhp_in_if.sink    stream,
	nhp_out_if.source marks
);
	import nhp_pkg::*;

	logic    res_valid;
	logic    res_ready;
	result_t res;

	// byte decode and state
	nhp_parse_core #(
		.MAX_HEADER_LEN (MAX_HEADER_LEN)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.stream    (stream),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// result register
	nhp_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.marks     (marks)
	);

endmodule
